/* rtl/ttag_pkg.sv */
// Shared constants, types and helper functions of the tensor transpose address generator.
// No dependencies. Used by every module under rtl/.
`default_nettype none

package ttag_pkg;

	// Core sizing
	localparam int MAX_RANK    = 4;
	localparam int EXTENT_BITS = 12;
	localparam int IDX_W       = 48;

	// Register field widths
	localparam int RANK_W       = 3;
	localparam int EXT_CFG_W    = 13;
	localparam int AXIS_CFG_W   = 12;
	localparam int AXIS_FIELD_W = 3;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 3;
	localparam int NUM_EXT_REGS = 4;

	// Reset values of the registers
	localparam logic [RANK_W-1:0]     RANK_RESET   = RANK_W'(4);
	localparam logic [EXT_CFG_W-1:0]  EXT_RESET    = EXT_CFG_W'(1);
	localparam logic [AXIS_CFG_W-1:0] AXIS_RESET   = '0;
	localparam logic                  REVERSE_RESET = 1'b1;

	// Derived widths
	localparam int COORD_W  = EXTENT_BITS;
	localparam int EXT_W    = EXTENT_BITS + 1;
	localparam int ERANK_W  = $clog2(MAX_RANK + 1);
	localparam int NORM_W   = ERANK_W + 2;
	localparam int PERM_W   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int STRIDE_FULL_W = EXTENT_BITS * (MAX_RANK - 1) + 1;
	localparam int STRIDE_W = (STRIDE_FULL_W < IDX_W) ? STRIDE_FULL_W : IDX_W;

	// Pipeline and output queue sizing
	localparam int SUM_LVL     = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int SUM_LEAVES  = 1 << SUM_LVL;
	localparam int PIPE_DEPTH  = MAX_RANK + 1 + SUM_LVL;
	localparam int QUEUE_DEPTH = 1 << $clog2(PIPE_DEPTH + 2);
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// Register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RANK        = 3'd0,
		REG_EXTENT_0    = 3'd1,
		REG_EXTENT_1    = 3'd2,
		REG_EXTENT_2    = 3'd3,
		REG_EXTENT_3    = 3'd4,
		REG_AXIS_ORDER  = 3'd5,
		REG_USE_REVERSE = 3'd6
	} cfg_reg_t;

	// Per-cell odometer control
	typedef struct packed {
		logic advance;
		logic restart;
		logic active;
	} cell_ctrl_t;

	// One finished result
	typedef struct packed {
		logic [IDX_W-1:0] dst;
		logic [IDX_W-1:0] src;
		logic             last;
		logic             bad;
	} result_t;

	// Clamp the rank register to 1..MAX_RANK
	function automatic logic [ERANK_W-1:0] eff_rank(input logic [RANK_W-1:0] r);
		int v;
		v = int'(r);
		if (v < 1) v = 1;
		if (v > MAX_RANK) v = MAX_RANK;
		return ERANK_W'(v);
	endfunction

	// Clamp an extent register to 1..2^EXTENT_BITS
	function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_CFG_W-1:0] e);
		int v;
		v = int'(e);
		if (v < 1) v = 1;
		if (v > (1 << EXTENT_BITS)) v = 1 << EXTENT_BITS;
		return EXT_W'(v);
	endfunction

	// Pick the source-axis field of one output axis, zero past the register
	function automatic logic [AXIS_FIELD_W-1:0] axis_field(input logic [AXIS_CFG_W-1:0] ao,
			input int d);
		logic [AXIS_CFG_W-1:0] sh;
		sh = ao >> (AXIS_FIELD_W * d);
		return sh[AXIS_FIELD_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/ttag_cell.sv */
// One cell of the odometer chain: an output coordinate digit, its delay line and its
// source term, plus the input stride of the axis with the same number. Uses ttag_pkg.
`default_nettype none

module ttag_cell (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ttag_pkg::cell_ctrl_t             ctrl,
	input  wire logic [ttag_pkg::COORD_W-1:0]     oext_m1,
	input  wire logic                             carry_in,
	output logic                                  carry_out,
	output logic                                  at_last,
	input  wire logic [ttag_pkg::STRIDE_W-1:0]    stride_in,
	input  wire logic [ttag_pkg::EXT_W-1:0]       ext_in,
	output logic [ttag_pkg::STRIDE_W-1:0]         stride,
	input  wire logic [ttag_pkg::STRIDE_W-1:0]    stride_sel,
	output logic [ttag_pkg::IDX_W-1:0]            term
);

	localparam int PROD_W   = ttag_pkg::COORD_W + ttag_pkg::STRIDE_W;
	localparam int SPROD_W  = ttag_pkg::STRIDE_W + ttag_pkg::EXT_W;

	logic [ttag_pkg::COORD_W-1:0]  coord_q;
	logic [ttag_pkg::COORD_W-1:0]  coord_cur;
	logic                          wrap;
	logic [ttag_pkg::COORD_W-1:0]  coord_dly_q [ttag_pkg::MAX_RANK];
	logic [PROD_W-1:0]             prod;
	logic [ttag_pkg::IDX_W-1:0]    term_q;
	logic [SPROD_W-1:0]            stride_prod;
	logic [ttag_pkg::STRIDE_W-1:0] stride_q;

	// Digit as seen by this transaction
	assign coord_cur = ctrl.restart ? '0 : coord_q;
	assign wrap      = (coord_cur >= oext_m1);
	assign carry_out = ctrl.active && carry_in && wrap;
	assign at_last   = (coord_cur == oext_m1);

	// Advance the digit on acceptance; restart clears unused digits too
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_q <= '0;
		end else if (ctrl.advance) begin
			if (ctrl.active && carry_in) begin
				coord_q <= wrap ? '0 : coord_cur + ttag_pkg::COORD_W'(1);
			end else begin
				coord_q <= coord_cur;
			end
		end
	end

	// Delay the digit until the strides have settled
	always_ff @(posedge clk) begin
		coord_dly_q[0] <= coord_cur;
		for (int k = 1; k < ttag_pkg::MAX_RANK; k++) begin
			coord_dly_q[k] <= coord_dly_q[k-1];
		end
	end

	// Weight the digit by the stride of its source axis
	assign prod = coord_dly_q[ttag_pkg::MAX_RANK-1] * stride_sel;

	always_ff @(posedge clk) begin
		term_q <= ctrl.active ? ttag_pkg::IDX_W'(prod) : '0;
	end

	assign term = term_q;

	// Input stride: product of the extents inside this axis, fed by the inner neighbor
	assign stride_prod = stride_in * ext_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= ttag_pkg::STRIDE_W'(1);
		end else begin
			stride_q <= ttag_pkg::STRIDE_W'(stride_prod);
		end
	end

	assign stride = stride_q;

endmodule

`default_nettype wire

/* rtl/ttag_sum.sv */
// Registered adder tree that folds the cell terms into the source index.
// Uses ttag_pkg.
`default_nettype none

module ttag_sum (
	input  wire logic                          clk,
	input  wire logic [ttag_pkg::IDX_W-1:0]    terms [ttag_pkg::MAX_RANK],
	output logic [ttag_pkg::IDX_W-1:0]         sum
);

	localparam int LEAVES = ttag_pkg::SUM_LEAVES;

	logic [ttag_pkg::IDX_W-1:0] leaf   [LEAVES];
	logic [ttag_pkg::IDX_W-1:0] node_q [1:LEAVES-1];

	// Pad the leaves to a power of two
	for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
		if (i < ttag_pkg::MAX_RANK) begin : g_term
			assign leaf[i] = terms[i];
		end else begin : g_pad
			assign leaf[i] = '0;
		end
	end

	// Heap-ordered nodes, each level registered
	for (genvar i = 1; i < LEAVES; i++) begin : g_node
		if (2 * i >= LEAVES) begin : g_bottom
			always_ff @(posedge clk) begin
				node_q[i] <= leaf[2*i-LEAVES] + leaf[2*i+1-LEAVES];
			end
		end else begin : g_upper
			always_ff @(posedge clk) begin
				node_q[i] <= node_q[2*i] + node_q[2*i+1];
			end
		end
	end

	assign sum = node_q[1];

endmodule

`default_nettype wire

/* rtl/ttag_queue.sv */
// Output queue that decouples the fixed-latency pipeline from the result consumer.
// Uses ttag_pkg.
`default_nettype none

module ttag_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire ttag_pkg::result_t   push_data,
	input  wire logic                pop,
	output logic                     head_valid,
	output ttag_pkg::result_t        head
);

	ttag_pkg::result_t            slot_q [ttag_pkg::QUEUE_DEPTH];
	logic [ttag_pkg::QPTR_W:0]    wr_ptr_q;
	logic [ttag_pkg::QPTR_W:0]    rd_ptr_q;

	// Advance the pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + (ttag_pkg::QPTR_W+1)'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + (ttag_pkg::QPTR_W+1)'(1);
		end
	end

	// Store the incoming result
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q[ttag_pkg::QPTR_W-1:0]] <= push_data;
	end

	assign head_valid = (wr_ptr_q != rd_ptr_q);
	assign head       = slot_q[rd_ptr_q[ttag_pkg::QPTR_W-1:0]];

endmodule

`default_nettype wire

/* rtl/tensor_transpose_address_gen.sv */
// A result is offered once its transaction has passed the digit delay line, term multiply,
// adder tree and output queue write, and can be taken at the next edge.
// Throughput: one transaction per cycle while in_ready is high; the odometer carry ripples
// combinationally through all cells. The 16-entry output queue absorbs consumer stalls.
// Reset: registers return to their defaults, odometer and destination counter clear;
// the first transaction may be accepted in the cycle after reset.
`default_nettype none

module tensor_transpose_address_gen (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [ttag_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [ttag_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                restart,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [ttag_pkg::IDX_W-1:0]               dst_index,
	output logic [ttag_pkg::IDX_W-1:0]               src_index,
	output logic                                     last,
	output logic                                     bad_axis
);

	localparam int M = ttag_pkg::MAX_RANK;

	typedef struct packed {
		logic [ttag_pkg::IDX_W-1:0] dst;
		logic                       last;
		logic                       bad;
	} meta_t;

	// Registers
	logic [ttag_pkg::RANK_W-1:0]     rank_q;
	logic [ttag_pkg::EXT_CFG_W-1:0]  extent_q [M];
	logic [ttag_pkg::AXIS_CFG_W-1:0] axis_order_q;
	logic                            use_reverse_q;

	// Derived configuration
	logic [ttag_pkg::ERANK_W-1:0]        erank;
	logic signed [ttag_pkg::NORM_W-1:0]  rank_s;
	logic [ttag_pkg::EXT_W-1:0]          ext_eff [M];
	logic [M-1:0]                        active;
	logic signed [ttag_pkg::NORM_W-1:0]  v_norm [M];
	logic [M-1:0]                        axis_bad;
	logic                                bad_any;
	logic [ttag_pkg::PERM_W-1:0]         perm [M];

	// Cell chain wiring
	ttag_pkg::cell_ctrl_t                cell_ctrl [M];
	logic [ttag_pkg::COORD_W-1:0]        oext_m1 [M];
	logic [M-1:0]                        carry_in;
	logic [M-1:0]                        carry_out;
	logic [M-1:0]                        at_last;
	logic [ttag_pkg::STRIDE_W-1:0]       stride_in [M];
	logic [ttag_pkg::EXT_W-1:0]          ext_in [M];
	logic [ttag_pkg::STRIDE_W-1:0]       stride_w [M];
	logic [ttag_pkg::STRIDE_W-1:0]       stride_sel [M];
	logic [ttag_pkg::IDX_W-1:0]          term [M];
	logic [ttag_pkg::IDX_W-1:0]          src_sum;

	// Transaction control
	logic                                accept;
	logic                                pop;
	logic                                last_now;
	logic [ttag_pkg::IDX_W-1:0]          dst_q;
	logic [ttag_pkg::IDX_W-1:0]          dst_cur;
	logic [ttag_pkg::PIPE_DEPTH-1:0]     valid_q;
	meta_t                               meta_dly_q [ttag_pkg::PIPE_DEPTH];
	logic [ttag_pkg::QCNT_W-1:0]         out_cnt_q;
	ttag_pkg::result_t                   push_data;
	ttag_pkg::result_t                   head;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q        <= ttag_pkg::RANK_RESET;
			axis_order_q  <= ttag_pkg::AXIS_RESET;
			use_reverse_q <= ttag_pkg::REVERSE_RESET;
			for (int k = 0; k < M; k++) begin
				extent_q[k] <= ttag_pkg::EXT_RESET;
			end
		end else if (cfg_we) begin
			unique case (ttag_pkg::cfg_reg_t'(cfg_index))
				ttag_pkg::REG_RANK:        rank_q <= cfg_data[ttag_pkg::RANK_W-1:0];
				ttag_pkg::REG_AXIS_ORDER:  axis_order_q <= cfg_data[ttag_pkg::AXIS_CFG_W-1:0];
				ttag_pkg::REG_USE_REVERSE: use_reverse_q <= cfg_data[0];
				default: ;
			endcase
			for (int k = 0; k < M; k++) begin
				if (k < ttag_pkg::NUM_EXT_REGS && cfg_index ==
						ttag_pkg::CFG_INDEX_W'(int'(ttag_pkg::REG_EXTENT_0) + k)) begin
					extent_q[k] <= cfg_data[ttag_pkg::EXT_CFG_W-1:0];
				end
			end
		end
	end

	// Clamp rank and extents
	assign erank  = ttag_pkg::eff_rank(rank_q);
	assign rank_s = signed'(ttag_pkg::NORM_W'(erank));

	always_comb begin
		for (int d = 0; d < M; d++) begin
			ext_eff[d] = ttag_pkg::eff_extent(extent_q[d]);
			active[d]  = (ttag_pkg::ERANK_W'(d) < erank);
		end
	end

	// Normalize negative axes and range-check them; reversed axes are never bad
	always_comb begin
		for (int d = 0; d < M; d++) begin
			v_norm[d] = ttag_pkg::NORM_W'(signed'(ttag_pkg::axis_field(axis_order_q, d)));
			if (v_norm[d] < 0) v_norm[d] = v_norm[d] + rank_s;
			axis_bad[d] = active[d] && !use_reverse_q &&
				(v_norm[d] < 0 || v_norm[d] >= rank_s);
		end
	end

	assign bad_any = |axis_bad;

	// Resolve the permutation: reversed, identity on error, or as given
	always_comb begin
		for (int d = 0; d < M; d++) begin
			if (!active[d]) begin
				perm[d] = '0;
			end else if (use_reverse_q) begin
				perm[d] = ttag_pkg::PERM_W'(int'(erank) - 1 - d);
			end else if (bad_any) begin
				perm[d] = ttag_pkg::PERM_W'(d);
			end else begin
				perm[d] = ttag_pkg::PERM_W'(v_norm[d]);
			end
		end
	end

	// Per-cell extents and strides of the selected source axis
	always_comb begin
		for (int d = 0; d < M; d++) begin
			oext_m1[d]    = ttag_pkg::COORD_W'(ext_eff[perm[d]] - ttag_pkg::EXT_W'(1));
			stride_sel[d] = stride_w[perm[d]];
			cell_ctrl[d]  = '{advance: accept, restart: restart, active: active[d]};
		end
	end

	// Cell chain: carries and strides run from the innermost cell outward
	for (genvar d = 0; d < M; d++) begin : g_cell
		if (d == M - 1) begin : g_inner
			assign carry_in[d]  = (erank == ttag_pkg::ERANK_W'(M));
			assign stride_in[d] = ttag_pkg::STRIDE_W'(1);
			assign ext_in[d]    = ttag_pkg::EXT_W'(1);
		end else begin : g_outer
			assign carry_in[d]  = (erank == ttag_pkg::ERANK_W'(d + 1)) ? 1'b1 : carry_out[d+1];
			assign stride_in[d] = stride_w[d+1];
			assign ext_in[d]    = active[d+1] ? ext_eff[d+1] : ttag_pkg::EXT_W'(1);
		end

		ttag_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl[d]),
			.oext_m1    (oext_m1[d]),
			.carry_in   (carry_in[d]),
			.carry_out  (carry_out[d]),
			.at_last    (at_last[d]),
			.stride_in  (stride_in[d]),
			.ext_in     (ext_in[d]),
			.stride     (stride_w[d]),
			.stride_sel (stride_sel[d]),
			.term       (term[d])
		);
	end

	// Fold the terms into the source index
	ttag_sum u_sum (
		.clk   (clk),
		.terms (term),
		.sum   (src_sum)
	);

	// Handshakes
	assign in_ready = (out_cnt_q < ttag_pkg::QCNT_W'(ttag_pkg::QUEUE_DEPTH));
	assign accept   = in_valid && in_ready;
	assign pop      = out_valid && out_ready;

	// Last element: every used digit sits at its extent minus one
	assign last_now = &(~active | at_last);
	assign dst_cur  = restart ? '0 : dst_q;

	// Count destination elements, wrap after last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_q <= '0;
		end else if (accept) begin
			dst_q <= last_now ? '0 : dst_cur + ttag_pkg::IDX_W'(1);
		end
	end

	// Track transactions through the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[ttag_pkg::PIPE_DEPTH-2:0], accept};
		end
	end

	// Carry destination index and flags alongside the source computation
	always_ff @(posedge clk) begin
		meta_dly_q[0] <= '{dst: dst_cur, last: last_now, bad: bad_any};
		for (int k = 1; k < ttag_pkg::PIPE_DEPTH; k++) begin
			meta_dly_q[k] <= meta_dly_q[k-1];
		end
	end

	// Count transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (accept && !pop) begin
			out_cnt_q <= out_cnt_q + ttag_pkg::QCNT_W'(1);
		end else if (pop && !accept) begin
			out_cnt_q <= out_cnt_q - ttag_pkg::QCNT_W'(1);
		end
	end

	// Queue finished results
	assign push_data = '{
		dst:  meta_dly_q[ttag_pkg::PIPE_DEPTH-1].dst,
		src:  src_sum,
		last: meta_dly_q[ttag_pkg::PIPE_DEPTH-1].last,
		bad:  meta_dly_q[ttag_pkg::PIPE_DEPTH-1].bad
	};

	ttag_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (valid_q[ttag_pkg::PIPE_DEPTH-1]),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (out_valid),
		.head       (head)
	);

	assign dst_index = head.dst;
	assign src_index = head.src;
	assign last      = head.last;
	assign bad_axis  = head.bad;

	// Outstanding count never exceeds the queue
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= ttag_pkg::QCNT_W'(ttag_pkg::QUEUE_DEPTH))
		else $error("outstanding count exceeds queue depth");

	// A result leaving the pipeline belongs to a counted transaction
	a_push_owned: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[ttag_pkg::PIPE_DEPTH-1] |-> out_cnt_q != '0)
		else $error("pipeline result without outstanding transaction");

	// An offered result belongs to a counted transaction
	a_out_owned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_cnt_q != '0)
		else $error("queued result without outstanding transaction");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Testbench for tensor_transpose_address_gen: a scoreboard predicts every gather address
// from the configured shape and permutation, and results are checked in order.
// Depends on rtl/ttag_pkg.sv and rtl/tensor_transpose_address_gen.sv.

import ttag_pkg::*;

class gather_scoreboard;
	// Register shadow
	logic [RANK_W-1:0]     rank_reg;
	logic [EXT_CFG_W-1:0]  extent_reg[MAX_RANK];
	logic [AXIS_CFG_W-1:0] order_reg;
	logic                  reverse_reg;

	// Odometer shadow
	logic [COORD_W-1:0] coord[MAX_RANK];
	logic [IDX_W-1:0]   dst_count;

	result_t pending_addrs[$];
	int      errors;

	function new();
		int d;
		rank_reg = RANK_RESET;
		for (d = 0; d < MAX_RANK; d++) begin
			extent_reg[d] = EXT_RESET;
			coord[d] = '0;
		end
		order_reg = AXIS_RESET;
		reverse_reg = REVERSE_RESET;
		dst_count = '0;
		errors = 0;
	endfunction

	function void apply_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_RANK: rank_reg = val[RANK_W-1:0];
			REG_EXTENT_0, REG_EXTENT_1, REG_EXTENT_2, REG_EXTENT_3:
				extent_reg[int'(idx) - int'(REG_EXTENT_0)] = val[EXT_CFG_W-1:0];
			REG_AXIS_ORDER: order_reg = val[AXIS_CFG_W-1:0];
			REG_USE_REVERSE: reverse_reg = val[0];
			default: ;
		endcase
	endfunction

	function logic [EXT_W-1:0] clamp_extent(logic [EXT_CFG_W-1:0] e);
		if (e == '0) return EXT_W'(1);
		if (int'(e) > (1 << EXTENT_BITS)) return EXT_W'(1 << EXTENT_BITS);
		return EXT_W'(e);
	endfunction

	// Predict the address of one accepted transaction, then advance the odometer
	function void note_step(logic rs);
		int r, d, a, v;
		int perm[MAX_RANK];
		logic [EXT_W-1:0] oext[MAX_RANK];
		logic [IDX_W-1:0] stride[MAX_RANK];
		logic [IDX_W-1:0] s, src;
		logic [EXT_W-1:0] c;
		logic bad, at_end;
		result_t res;

		r = int'(rank_reg);
		if (r < 1) r = 1;
		if (r > MAX_RANK) r = MAX_RANK;

		// Resolve the permutation; negative axes count from the rank
		bad = 1'b0;
		for (d = 0; d < MAX_RANK; d++) perm[d] = d;
		for (d = 0; d < r; d++) begin
			if (reverse_reg) begin
				perm[d] = r - 1 - d;
			end else begin
				v = int'(order_reg[AXIS_FIELD_W*d +: AXIS_FIELD_W]);
				if (v >= 4) v -= 8;
				if (v < 0) v += r;
				if (v < 0 || v >= r) bad = 1'b1;
				else perm[d] = v;
			end
		end
		// Fall back to the identity walk on a bad axis
		if (bad) for (d = 0; d < MAX_RANK; d++) perm[d] = d;

		s = IDX_W'(1);
		for (a = r - 1; a >= 0; a--) begin
			stride[a] = s;
			s = s * IDX_W'(clamp_extent(extent_reg[a]));
		end
		for (d = 0; d < r; d++) oext[d] = clamp_extent(extent_reg[perm[d]]);

		if (rs) begin
			for (d = 0; d < MAX_RANK; d++) coord[d] = '0;
			dst_count = '0;
		end

		src = '0;
		at_end = 1'b1;
		for (d = 0; d < r; d++) begin
			src = src + IDX_W'(coord[d]) * stride[perm[d]];
			if (EXT_W'(coord[d]) != oext[d] - 1'b1) at_end = 1'b0;
		end

		res.dst = dst_count;
		res.src = src;
		res.last = at_end;
		res.bad = bad;
		pending_addrs.insert(pending_addrs.size(), res);

		// Carry from the innermost output axis
		for (a = r - 1; a >= 0; a--) begin
			c = EXT_W'(coord[a]) + 1'b1;
			if (c < oext[a]) begin
				coord[a] = c[COORD_W-1:0];
				break;
			end
			coord[a] = '0;
		end
		dst_count = at_end ? '0 : dst_count + 1'b1;
	endfunction

	task report(string msg);
		errors++;
		$display("tb: mismatch at %0t: %s", $time, msg);
	endtask

	task check_gather(result_t got);
		result_t want;
		if (pending_addrs.size() == 0) begin
			report($sformatf("result with none pending: dst %0d src %0d", got.dst, got.src));
			return;
		end
		want = pending_addrs.pop_front();
		if (got.dst !== want.dst)
			report($sformatf("dst_index %0d, predicted %0d", got.dst, want.dst));
		if (got.src !== want.src)
			report($sformatf("src_index %0d, predicted %0d (dst %0d)", got.src, want.src, want.dst));
		if (got.last !== want.last)
			report($sformatf("last %b, predicted %b (dst %0d)", got.last, want.last, want.dst));
		if (got.bad !== want.bad)
			report($sformatf("bad_axis %b, predicted %b (dst %0d)", got.bad, want.bad, want.dst));
	endtask
endclass

module testbench;
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} traffic_t;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;	// unmapped index
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 1000;
	localparam int BUSY_PCT     = 48;
	localparam int MIXED_PCT    = 14;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   restart = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [IDX_W-1:0]       dst_index;
	logic [IDX_W-1:0]       src_index;
	logic                   last;
	logic                   bad_axis;

	int gap_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;
	result_t got;
	gather_scoreboard sb;

	tensor_transpose_address_gen u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dst_index(dst_index),
		.src_index(src_index),
		.last(last),
		.bad_axis(bad_axis)
	);

	always #1 clk = ~clk;

	// Stall the result channel at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Check results first, then note the transaction accepted at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.dst = dst_index;
				got.src = src_index;
				got.last = last;
				got.bad = bad_axis;
				sb.check_gather(got);
			end
			if (in_valid && in_ready) sb.note_step(restart);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic set_traffic(input traffic_t mode);
		case (mode)
			IDLE_SENDER: begin
				gap_pct = BUSY_PCT;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				gap_pct = 0;
				stall_pct = BUSY_PCT;
			end
			IDLE_BOTH: begin
				gap_pct = MIXED_PCT;
				stall_pct = MIXED_PCT;
			end
			default: begin
				gap_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.apply_write(idx, val);
		@(negedge clk);
	endtask

	// Offer one transaction, with random gaps ahead of it; returns at a falling edge
	task automatic send_item(input logic rs);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic run_items(input int n, input int restart_pct);
		int i;
		for (i = 0; i < n; i++) send_item($urandom_range(99) < restart_pct);
	endtask

	// Hold the input low until every predicted address has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending_addrs.size() != 0);
	endtask

	task automatic order_case(input logic [AXIS_CFG_W-1:0] order, input int n);
		drain();
		write_reg(REG_AXIS_ORDER, CFG_DATA_W'(order));
		cfg_we <= 1'b0;
		send_item(1'b1);
		run_items(n - 1, 0);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_extent();
		int roll;
		roll = $urandom_range(99);
		if (roll < 78) return CFG_DATA_W'($urandom_range(1, 3));
		if (roll < 88) return CFG_DATA_W'($urandom_range(4, 7));
		if (roll < 92) return '0;
		if (roll < 95) return CFG_DATA_W'(1 << EXTENT_BITS);
		if (roll < 97) return '1;
		return CFG_DATA_W'($urandom());
	endfunction

	// Pick a new shape and permutation; some registers keep their old value
	task automatic random_setup();
		int er, j, t, d;
		int order[MAX_RANK];
		logic [RANK_W-1:0] r;
		logic [AXIS_CFG_W-1:0] ao;
		logic [CFG_DATA_W-1:0] junk;

		junk = CFG_DATA_W'($urandom());
		if ($urandom_range(3) != 0) junk = '0;
		r = ($urandom_range(99) < 85) ? RANK_W'($urandom_range(1, 4)) : RANK_W'($urandom());
		write_reg(REG_RANK, {junk[CFG_DATA_W-1:RANK_W], r});

		for (j = 0; j < NUM_EXT_REGS; j++)
			if ($urandom_range(99) < 85)
				write_reg(CFG_INDEX_W'(int'(REG_EXTENT_0) + j), pick_extent());

		// Shuffle a valid permutation, encoding some axes as negative
		er = (r == '0) ? 1 : ((int'(r) > MAX_RANK) ? MAX_RANK : int'(r));
		for (d = 0; d < MAX_RANK; d++) order[d] = d;
		for (d = er - 1; d > 0; d--) begin
			j = $urandom_range(d);
			t = order[d];
			order[d] = order[j];
			order[j] = t;
		end
		ao = AXIS_CFG_W'($urandom());
		for (d = 0; d < er; d++)
			ao[AXIS_FIELD_W*d +: AXIS_FIELD_W] = ($urandom_range(1) != 0) ?
				AXIS_FIELD_W'(order[d] - er) : AXIS_FIELD_W'(order[d]);
		// Raw patterns bring out-of-range and repeated axes
		if ($urandom_range(99) < 12) ao = AXIS_CFG_W'($urandom());
		if ($urandom_range(99) < 85) write_reg(REG_AXIS_ORDER, {junk[CFG_DATA_W-1], ao});
		if ($urandom_range(99) < 85)
			write_reg(REG_USE_REVERSE, {junk[CFG_DATA_W-1:1], 1'($urandom_range(99) < 30)});
		if ($urandom_range(99) < 10) write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
		cfg_we <= 1'b0;
	endtask

	initial begin
		int phase, n, sent;

		sb = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset shape: a single element, so every transaction is the last
		run_items(2, 0);

		// Full register set with a negative axis
		drain();
		write_reg(REG_RANK, 13'd3);
		write_reg(REG_EXTENT_0, 13'd2);
		write_reg(REG_EXTENT_1, 13'd3);
		write_reg(REG_EXTENT_2, 13'd4);
		write_reg(REG_EXTENT_3, 13'd5);
		write_reg(REG_AXIS_ORDER, 13'h047);
		write_reg(REG_USE_REVERSE, 13'd0);
		write_reg(REG_SPARE, '1);
		cfg_we <= 1'b0;
		send_item(1'b1);
		run_items(5, 0);

		// Axis past the rank, negative axis below zero, repeated axis
		order_case(12'h043, 3);
		order_case(12'h060, 2);
		order_case(12'h009, 3);

		// Rank zero and extent zero
		drain();
		write_reg(REG_RANK, 13'd0);
		write_reg(REG_EXTENT_0, 13'd0);
		cfg_we <= 1'b0;
		send_item(1'b1);
		send_item(1'b0);

		// Saturated rank and extents
		drain();
		write_reg(REG_RANK, 13'd7);
		write_reg(REG_EXTENT_0, '1);
		write_reg(REG_EXTENT_1, 13'd4096);
		write_reg(REG_EXTENT_2, 13'd4095);
		write_reg(REG_EXTENT_3, 13'd0);
		write_reg(REG_USE_REVERSE, 13'd1);
		cfg_we <= 1'b0;
		send_item(1'b1);
		run_items(2, 0);

		// Shrink mid-walk: coordinates above the new extents must wrap
		drain();
		write_reg(REG_EXTENT_0, 13'd2);
		write_reg(REG_EXTENT_1, 13'd2);
		write_reg(REG_EXTENT_2, 13'd2);
		write_reg(REG_EXTENT_3, 13'd2);
		write_reg(REG_AXIS_ORDER, 13'h688);
		write_reg(REG_USE_REVERSE, 13'd0);
		cfg_we <= 1'b0;
		run_items(4, 0);

		// Random phases, cycling through the traffic patterns
		phase = 0;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			random_setup();
			set_traffic(traffic_t'(phase % 4));
			n = $urandom_range(20, 70);
			if (phase % 3 == 0) begin
				run_items(n / 2, 4);
				drain();
				run_items(n - n / 2, 4);
			end else begin
				run_items(n, 4);
			end
			sent += n;
			phase++;
		end

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
